@@ design/lpc_pkg.sv @@
// Shared types and constants for the LRU page cache read simulator.
package lpc_pkg;

   localparam int unsigned MAX_ENTRIES = 4096;
   localparam int unsigned IDX_W = $clog2(MAX_ENTRIES);
   localparam int unsigned ENTRY_W = IDX_W + 1;
   localparam logic [ENTRY_W-1:0] NIL_IDX = ENTRY_W'(MAX_ENTRIES);
   localparam int unsigned PAGE_W = 45;
   localparam int unsigned CNT_W = 64;
   localparam int unsigned LAT_W = 16;
   localparam int unsigned CAP_W = 13;
   localparam int unsigned NPAGE_W = 7;
   localparam int unsigned MAX_RESULTS = 64;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DATA_W = 16;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HIT_LAT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MISS_LAT = 2'd2;

   localparam logic [CAP_W-1:0] CAP_RESET = 13'd2560;
   localparam logic [LAT_W-1:0] HIT_LAT_RESET = 16'd7;
   localparam logic [LAT_W-1:0] MISS_LAT_RESET = 16'd128;

   localparam logic OP_READ = 1'b0;

   typedef struct packed {
      logic        opcode;
      logic [47:0] sector_number;
      logic [17:0] byte_count;
   } req_type;

   typedef struct packed {
      logic [PAGE_W-1:0] page_number;
      logic              hit;
      logic              last;
      logic [CNT_W-1:0]  hits_so_far;
      logic [CNT_W-1:0]  misses_so_far;
      logic [CNT_W-1:0]  latency_so_far;
      logic [CNT_W-1:0]  reads_so_far;
   } rsp_type;

   typedef struct packed {
      logic [CAP_W-1:0] capacity;
      logic [LAT_W-1:0] hit_lat;
      logic [LAT_W-1:0] miss_lat;
   } cfg_type;

endpackage

@@ design/lru_page_cache_read_sim_unit.sv @@
// Top level of the LRU page cache read simulator.
//
//   channel | direction | handshake     | carries
//   req_    | in        | valid / stall | one storage request
//   rsp_    | out       | valid / stall | one result per page of a read
//   csr_    | in        | valid / ready | register index and write data
//
// A read leaves idle; per page it reads the bucket head and compares hash
// chain entries. A hit unlinks the entry and pushes it at the LRU head; a
// free-slot miss writes the tag and chain link, then pushes; an eviction
// first unhooks the victim from its chain and the LRU list. The memories
// are one-read, one-write. After reset a pass clears the bucket heads while
// req_stall is high. Writes and zero-length reads give no result. A stalled
// rsp_ holds the core at the next result while earlier work is done.
module lru_page_cache_read_sim_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  lpc_pkg::req_type                   req_payload,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output lpc_pkg::rsp_type                   rsp_payload,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [lpc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [lpc_pkg::CSR_DATA_W-1:0]     csr_data
);
   import lpc_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    out_free, out_load;
   rsp_type out_data;

   assign csr_ready = 1'b1;

   // Register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_CAPACITY: cfg_in.capacity = csr_data[CAP_W-1:0];
            CSR_HIT_LAT:  cfg_in.hit_lat = csr_data;
            CSR_MISS_LAT: cfg_in.miss_lat = csr_data;
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.capacity <= CAP_RESET;
         cfg_ff.hit_lat <= HIT_LAT_RESET;
         cfg_ff.miss_lat <= MISS_LAT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lpc_core u_core (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .cfg         (cfg_ff),
      .out_free    (out_free),
      .out_load    (out_load),
      .out_data    (out_data)
   );

   lpc_out u_out (
      .clock       (clock),
      .reset       (reset),
      .load        (out_load),
      .load_data   (out_data),
      .free        (out_free),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );
endmodule

@@ design/lpc_out.sv @@
// Output register that holds one result while the consumer stalls.
module lpc_out (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  lpc_pkg::rsp_type load_data,
   output logic             free,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output lpc_pkg::rsp_type rsp_payload
);
   import lpc_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   // The slot can take a new result when empty or being drained.
   assign free = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_payload = data_ff;
endmodule

@@ design/lpc_core.sv @@
// Sequencer and memories: hash chain lookup, LRU list update, eviction, counters.
module lpc_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  lpc_pkg::req_type req_payload,
   input  lpc_pkg::cfg_type cfg,
   input  logic             out_free,
   output logic             out_load,
   output lpc_pkg::rsp_type out_data
);
   import lpc_pkg::*;

   localparam logic [4:0] S_CLEAR   = 5'd0;
   localparam logic [4:0] S_IDLE    = 5'd1;
   localparam logic [4:0] S_LOOK    = 5'd2;
   localparam logic [4:0] S_HEAD    = 5'd3;
   localparam logic [4:0] S_CMP     = 5'd4;
   localparam logic [4:0] S_UNLINK  = 5'd5;
   localparam logic [4:0] S_PUSH    = 5'd6;
   localparam logic [4:0] S_PUSH2   = 5'd7;
   localparam logic [4:0] S_MISS    = 5'd8;
   localparam logic [4:0] S_EV_TAG  = 5'd9;
   localparam logic [4:0] S_EV_HEAD = 5'd10;
   localparam logic [4:0] S_EV_WALK = 5'd11;
   localparam logic [4:0] S_EV_UNRD = 5'd12;
   localparam logic [4:0] S_INS     = 5'd13;
   localparam logic [4:0] S_INS2    = 5'd14;
   localparam logic [4:0] S_RESULT  = 5'd15;

   // Memories with registered read data.
   logic [PAGE_W-1:0]  tag_mem    [MAX_ENTRIES];
   logic [ENTRY_W-1:0] chain_mem  [MAX_ENTRIES];
   logic [ENTRY_W-1:0] bucket_mem [MAX_ENTRIES];
   logic [ENTRY_W-1:0] prev_mem   [MAX_ENTRIES];
   logic [ENTRY_W-1:0] next_mem   [MAX_ENTRIES];

   logic [PAGE_W-1:0]  tag_q, tag_wd;
   logic [ENTRY_W-1:0] chain_q, bucket_q, prev_q, next_q;
   logic [ENTRY_W-1:0] chain_wd, bucket_wd, prev_wd, next_wd;
   logic [IDX_W-1:0]   tag_ra, tag_wa, chain_ra, chain_wa, bucket_ra, bucket_wa;
   logic [IDX_W-1:0]   lru_ra, prev_wa, next_wa;
   logic               tag_we, chain_we, bucket_we, prev_we, next_we;

   // Sequencer state.
   logic [4:0]         state_ff, state_in;
   logic [IDX_W-1:0]   clr_ff, clr_in;
   logic [PAGE_W-1:0]  first_ff, first_in, page_ff, page_in;
   logic [NPAGE_W-1:0] k_ff, k_in, np_ff, np_in;
   logic [ENTRY_W-1:0] entry_ff, entry_in, walk_ff, walk_in, link_ff, link_in;
   logic [IDX_W-1:0]   bkt_ff, bkt_in;
   logic               hit_ff, hit_in;
   logic [ENTRY_W-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [CAP_W-1:0]   occ_ff, occ_in, cap_eff;
   logic [CNT_W-1:0]   hits_ff, hits_in, misses_ff, misses_in;
   logic [CNT_W-1:0]   lat_ff, lat_in, reads_ff, reads_in;
   logic [18:0]        span;
   logic               last_page;

   always_ff @(posedge clock) begin
      if (tag_we) tag_mem[tag_wa] <= tag_wd;
      tag_q <= tag_mem[tag_ra];
   end
   always_ff @(posedge clock) begin
      if (chain_we) chain_mem[chain_wa] <= chain_wd;
      chain_q <= chain_mem[chain_ra];
   end
   always_ff @(posedge clock) begin
      if (bucket_we) bucket_mem[bucket_wa] <= bucket_wd;
      bucket_q <= bucket_mem[bucket_ra];
   end
   always_ff @(posedge clock) begin
      if (prev_we) prev_mem[prev_wa] <= prev_wd;
      prev_q <= prev_mem[lru_ra];
   end
   always_ff @(posedge clock) begin
      if (next_we) next_mem[next_wa] <= next_wd;
      next_q <= next_mem[lru_ra];
   end

   // Capacity clamped to the range the store supports.
   always_comb begin
      cap_eff = cfg.capacity;
      if (cfg.capacity == '0) begin
         cap_eff = CAP_W'(1);
      end else if (cfg.capacity > CAP_W'(MAX_ENTRIES)) begin
         cap_eff = CAP_W'(MAX_ENTRIES);
      end
   end

   assign span = 19'({req_payload.sector_number[2:0], 9'd0})
               + 19'(req_payload.byte_count) - 19'd1;
   assign last_page = (k_ff + NPAGE_W'(1)) == np_ff;
   assign req_stall = (state_ff != S_IDLE);

   // Next state, memory controls and result.
   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      first_in = first_ff;
      page_in = page_ff;
      k_in = k_ff;
      np_in = np_ff;
      entry_in = entry_ff;
      walk_in = walk_ff;
      link_in = link_ff;
      bkt_in = bkt_ff;
      hit_in = hit_ff;
      head_in = head_ff;
      tail_in = tail_ff;
      occ_in = occ_ff;
      hits_in = hits_ff;
      misses_in = misses_ff;
      lat_in = lat_ff;
      reads_in = reads_ff;
      tag_we = 1'b0; tag_wa = entry_ff[IDX_W-1:0]; tag_wd = page_ff;
      tag_ra = entry_ff[IDX_W-1:0];
      chain_we = 1'b0; chain_wa = entry_ff[IDX_W-1:0]; chain_wd = bucket_q;
      chain_ra = entry_ff[IDX_W-1:0];
      bucket_we = 1'b0; bucket_wa = page_ff[IDX_W-1:0]; bucket_wd = entry_ff;
      bucket_ra = page_ff[IDX_W-1:0];
      prev_we = 1'b0; prev_wa = entry_ff[IDX_W-1:0]; prev_wd = NIL_IDX;
      next_we = 1'b0; next_wa = entry_ff[IDX_W-1:0]; next_wd = head_ff;
      lru_ra = entry_ff[IDX_W-1:0];
      out_load = 1'b0;
      out_data.page_number = page_ff;
      out_data.hit = hit_ff;
      out_data.last = last_page;
      out_data.hits_so_far = hits_ff;
      out_data.misses_so_far = misses_ff;
      out_data.latency_so_far = lat_ff;
      out_data.reads_so_far = reads_ff;

      unique case (state_ff)
         // Sweep every bucket head to null after reset.
         S_CLEAR: begin
            bucket_we = 1'b1;
            bucket_wa = clr_ff;
            bucket_wd = NIL_IDX;
            clr_in = clr_ff + IDX_W'(1);
            if (clr_ff == IDX_W'(MAX_ENTRIES - 1)) state_in = S_IDLE;
         end
         // A request that spans more pages than one read may return is cut short.
         S_IDLE: begin
            if (req_valid && req_payload.opcode == OP_READ) begin
               reads_in = reads_ff + CNT_W'(1);
               first_in = req_payload.sector_number[47:3];
               np_in = (span[18:12] >= NPAGE_W'(MAX_RESULTS)) ? NPAGE_W'(MAX_RESULTS)
                     : span[18:12] + NPAGE_W'(1);
               k_in = '0;
               if (req_payload.byte_count != '0) state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            page_in = first_ff + PAGE_W'(k_ff);
            bucket_ra = page_in[IDX_W-1:0];
            state_in = S_HEAD;
         end
         S_HEAD: begin
            if (bucket_q[IDX_W]) begin
               state_in = S_MISS;
            end else begin
               entry_in = bucket_q;
               tag_ra = bucket_q[IDX_W-1:0];
               chain_ra = bucket_q[IDX_W-1:0];
               state_in = S_CMP;
            end
         end
         // Walk the hash chain one entry per cycle.
         S_CMP: begin
            if (tag_q == page_ff) begin
               hit_in = 1'b1;
               state_in = S_UNLINK;
            end else if (chain_q[IDX_W]) begin
               state_in = S_MISS;
            end else begin
               entry_in = chain_q;
               tag_ra = chain_q[IDX_W-1:0];
               chain_ra = chain_q[IDX_W-1:0];
               lru_ra = chain_q[IDX_W-1:0];
            end
         end
         // Remove the entry from the LRU list; the sentinel lives in registers.
         S_UNLINK: begin
            if (prev_q[IDX_W]) begin
               head_in = next_q;
            end else begin
               next_we = 1'b1;
               next_wa = prev_q[IDX_W-1:0];
               next_wd = next_q;
            end
            if (next_q[IDX_W]) begin
               tail_in = prev_q;
            end else begin
               prev_we = 1'b1;
               prev_wa = next_q[IDX_W-1:0];
               prev_wd = prev_q;
            end
            state_in = hit_ff ? S_PUSH : S_INS;
         end
         // Link the entry in at the most recent end.
         S_PUSH: begin
            next_we = 1'b1;
            next_wd = head_ff;
            if (head_ff[IDX_W]) begin
               tail_in = entry_ff;
            end else begin
               prev_we = 1'b1;
               prev_wa = head_ff[IDX_W-1:0];
               prev_wd = entry_ff;
            end
            state_in = S_PUSH2;
         end
         S_PUSH2: begin
            prev_we = 1'b1;
            prev_wd = NIL_IDX;
            head_in = entry_ff;
            state_in = S_RESULT;
         end
         // Take a free slot or evict the least recent entry.
         S_MISS: begin
            hit_in = 1'b0;
            if (occ_ff < cap_eff) begin
               entry_in = ENTRY_W'(occ_ff);
               occ_in = occ_ff + CAP_W'(1);
               state_in = S_INS;
            end else begin
               entry_in = tail_ff[IDX_W] ? '0 : tail_ff;
               tag_ra = entry_in[IDX_W-1:0];
               chain_ra = entry_in[IDX_W-1:0];
               state_in = S_EV_TAG;
            end
         end
         S_EV_TAG: begin
            link_in = chain_q;
            bkt_in = tag_q[IDX_W-1:0];
            bucket_ra = tag_q[IDX_W-1:0];
            state_in = S_EV_HEAD;
         end
         S_EV_HEAD: begin
            if (bucket_q == entry_ff) begin
               bucket_we = 1'b1;
               bucket_wa = bkt_ff;
               bucket_wd = link_ff;
               state_in = S_EV_UNRD;
            end else if (bucket_q[IDX_W]) begin
               state_in = S_EV_UNRD;
            end else begin
               walk_in = bucket_q;
               chain_ra = bucket_q[IDX_W-1:0];
               state_in = S_EV_WALK;
            end
         end
         S_EV_WALK: begin
            if (chain_q == entry_ff) begin
               chain_we = 1'b1;
               chain_wa = walk_ff[IDX_W-1:0];
               chain_wd = link_ff;
               state_in = S_EV_UNRD;
            end else if (chain_q[IDX_W]) begin
               state_in = S_EV_UNRD;
            end else begin
               walk_in = chain_q;
               chain_ra = chain_q[IDX_W-1:0];
            end
         end
         S_EV_UNRD: begin
            state_in = S_UNLINK;
         end
         // Write the tag and put the slot at the head of its hash chain.
         S_INS: begin
            tag_we = 1'b1;
            state_in = S_INS2;
         end
         S_INS2: begin
            chain_we = 1'b1;
            chain_wd = bucket_q;
            bucket_we = 1'b1;
            bucket_wd = entry_ff;
            state_in = S_PUSH;
         end
         // Update the counters and hand the result to the output register.
         S_RESULT: begin
            if (out_free) begin
               out_load = 1'b1;
               if (hit_ff) begin
                  hits_in = hits_ff + CNT_W'(1);
                  lat_in = lat_ff + CNT_W'(cfg.hit_lat);
               end else begin
                  misses_in = misses_ff + CNT_W'(1);
                  lat_in = lat_ff + CNT_W'(cfg.miss_lat);
               end
               out_data.hits_so_far = hits_in;
               out_data.misses_so_far = misses_in;
               out_data.latency_so_far = lat_in;
               k_in = k_ff + NPAGE_W'(1);
               state_in = last_page ? S_IDLE : S_LOOK;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         head_ff <= NIL_IDX;
         tail_ff <= NIL_IDX;
         occ_ff <= '0;
         hits_ff <= '0;
         misses_ff <= '0;
         lat_ff <= '0;
         reads_ff <= '0;
         k_ff <= '0;
         np_ff <= '0;
         hit_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         head_ff <= head_in;
         tail_ff <= tail_in;
         occ_ff <= occ_in;
         hits_ff <= hits_in;
         misses_ff <= misses_in;
         lat_ff <= lat_in;
         reads_ff <= reads_in;
         k_ff <= k_in;
         np_ff <= np_in;
         hit_ff <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      first_ff <= first_in;
      page_ff <= page_in;
      entry_ff <= entry_in;
      walk_ff <= walk_in;
      link_ff <= link_in;
      bkt_ff <= bkt_in;
   end
endmodule

@@ design/lpc_checker.sv @@
// Port-level checks for the LRU page cache read simulator, bound to the top level.
module lpc_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input lpc_pkg::rsp_type rsp_payload
);
   import lpc_pkg::*;

   // No result right after reset.
   a_no_rsp_after_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result shown right after reset");

   // Requests are held off while the bucket heads are cleared.
   a_clear_stall: assert property (@(posedge clock) reset |=> req_stall)
      else $error("request taken during clearing pass");

   // A stalled result keeps its contents.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_payload))
      else $error("stalled result changed");

   // The counter matching the hit flag has moved off zero.
   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.hit ? rsp_payload.hits_so_far != '0
                                     : rsp_payload.misses_so_far != '0))
      else $error("hit or miss count not counted");
endmodule

bind lru_page_cache_read_sim_unit lpc_checker u_lpc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
